[hw/rtl/rmq_pkg.sv]
package rmq_pkg;

  // Width of every matrix element and quaternion component.
  localparam int unsigned ElemW = 16;

  // Default number of fraction bits (Q2.14).
  localparam int unsigned FracBitsDef = 14;

  // Quotient bits that the dividers produce; anything larger saturates.
  localparam int unsigned QuotW = 17;

  // Branch codes as reported on branch_taken.
  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_DIAG0 = 2'd1,
    BR_DIAG1 = 2'd2,
    BR_DIAG2 = 2'd3
  } branch_e;

  // Applies the sign to a quotient magnitude and saturates to 16 bits.
  function automatic logic [ElemW-1:0] sat_signed(input logic [QuotW-1:0] mag,
                                                   input logic neg, input logic ovf);
    logic [ElemW-1:0] res;
    res = '0;
    if (!neg) begin
      if (ovf || (mag > QuotW'(32767))) res = 16'h7fff;
      else res = mag[ElemW-1:0];
    end else begin
      if (ovf || (mag > QuotW'(32768))) res = 16'h8000;
      else res = ElemW'(~mag + QuotW'(1));
    end
    return res;
  endfunction

endpackage

[hw/rtl/rmq_if.sv]
interface rmq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmq_pkg::ElemW-1:0]     row0_col0;
  logic signed [rmq_pkg::ElemW-1:0]     row0_col1;
  logic signed [rmq_pkg::ElemW-1:0]     row0_col2;
  logic signed [rmq_pkg::ElemW-1:0]     row1_col0;
  logic signed [rmq_pkg::ElemW-1:0]     row1_col1;
  logic signed [rmq_pkg::ElemW-1:0]     row1_col2;
  logic signed [rmq_pkg::ElemW-1:0]     row2_col0;
  logic signed [rmq_pkg::ElemW-1:0]     row2_col1;
  logic signed [rmq_pkg::ElemW-1:0]     row2_col2;

  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, input ready);
  modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                row1_col2, row2_col0, row2_col1, row2_col2, output ready);
endinterface

interface rmq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [rmq_pkg::ElemW-1:0]     quat_w;
  logic signed [rmq_pkg::ElemW-1:0]     quat_x;
  logic signed [rmq_pkg::ElemW-1:0]     quat_y;
  logic signed [rmq_pkg::ElemW-1:0]     quat_z;
  logic [1:0]                           branch_taken;
  logic                                 radicand_bad;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, radicand_bad,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, radicand_bad,
                output ready);
endinterface

[hw/rtl/rotation_matrix_to_quaternion_core.sv]
// Channel  | Direction | Contents
// in_i     | sink      | one 3x3 matrix, nine Q2.14 elements
// out_o    | source    | quaternion w, x, y, z, branch code, radicand flag
//
// One transaction is accepted per cycle unless the output stalls. SW is the
// number of square root digits (one digit per stage) and QuotW is the number
// of quotient bits (one bit per divider stage).
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall freezes every stage in place.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FracBitsDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  rmq_in_if.sink   in_i,
  rmq_out_if.source out_o
);

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned EW = rmq_pkg::ElemW;
  localparam int unsigned QW = rmq_pkg::QuotW;
  // Radicand width, signed, wide enough for ONE plus three elements.
  localparam int unsigned RW = F + 19;
  // Square root digits and the padded radicand width.
  localparam int unsigned SW = (RW + F + 1) / 2;
  localparam int unsigned NW = 2 * SW;
  // Divider datapath width.
  localparam int unsigned PA = EW + F + 3;
  localparam int unsigned PB = SW + QW + 2;
  localparam int unsigned PW = (PA > PB) ? PA : PB;
  localparam int unsigned DW = EW + 1;

  // Every stage moves when the output register can take a new item.
  logic adv;
  assign adv      = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // ---------------------------------------------------------------------------
  // Prep: trace, branch selection, radicand clamp, and the three sums or
  // differences that become the non-diagonal components.
  // ---------------------------------------------------------------------------
  logic signed [RW-1:0] m00, m11, m22, t_s, r_s, one_s;
  logic [1:0]           br_c;
  logic                 bad_c;
  logic [NW-1:0]        n_c;
  logic signed [DW-1:0] da_c, db_c, dc_c;
  logic signed [DW-1:0] dx01, dx02, dx12, dz01, dz02, dz12;

  always_comb begin
    m00   = RW'(in_i.row0_col0);
    m11   = RW'(in_i.row1_col1);
    m22   = RW'(in_i.row2_col2);
    one_s = RW'(1) << F;
    t_s   = m00 + m11 + m22;
    // Differences for w (or x, y, z on the trace branch), sums for vector parts.
    dx12 = DW'(in_i.row2_col1) - DW'(in_i.row1_col2);
    dx02 = DW'(in_i.row0_col2) - DW'(in_i.row2_col0);
    dx01 = DW'(in_i.row1_col0) - DW'(in_i.row0_col1);
    dz01 = DW'(in_i.row0_col1) + DW'(in_i.row1_col0);
    dz02 = DW'(in_i.row2_col0) + DW'(in_i.row0_col2);
    dz12 = DW'(in_i.row1_col2) + DW'(in_i.row2_col1);
    if (t_s > 0) begin
      br_c = rmq_pkg::BR_TRACE;
      r_s  = one_s + t_s;
      da_c = dx12; db_c = dx02; dc_c = dx01;
    end else if ((m00 > m11) && (m00 > m22)) begin
      br_c = rmq_pkg::BR_DIAG0;
      r_s  = one_s + m00 - m11 - m22;
      da_c = dx12; db_c = dz01; dc_c = dz02;
    end else if (m11 > m22) begin
      br_c = rmq_pkg::BR_DIAG1;
      r_s  = one_s + m11 - m00 - m22;
      da_c = dx02; db_c = dz01; dc_c = dz12;
    end else begin
      br_c = rmq_pkg::BR_DIAG2;
      r_s  = one_s + m22 - m00 - m11;
      da_c = dx01; db_c = dz02; dc_c = dz12;
    end
    // A radicand at or below zero is clamped to one LSB.
    bad_c = (r_s <= 0);
    if (bad_c) r_s = RW'(1);
    n_c = NW'(r_s[RW-2:0]) << F;
  end

  // ---------------------------------------------------------------------------
  // Square root: one result digit per stage. Index 0 is the prep register.
  // ---------------------------------------------------------------------------
  logic                 sq_vld_q  [SW+1];
  logic [NW-1:0]        sq_n_q    [SW+1];
  logic [SW-1:0]        sq_root_q [SW+1];
  logic [SW+1:0]        sq_rem_q  [SW+1];
  logic [1:0]           sq_br_q   [SW+1];
  logic                 sq_bad_q  [SW+1];
  logic signed [DW-1:0] sq_d_q    [SW+1][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_n_q[0]    <= n_c;
      sq_root_q[0] <= '0;
      sq_rem_q[0]  <= '0;
      sq_br_q[0]   <= br_c;
      sq_bad_q[0]  <= bad_c;
      sq_d_q[0][0] <= da_c;
      sq_d_q[0][1] <= db_c;
      sq_d_q[0][2] <= dc_c;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [SW+3:0] rem_w, trial_w;

    always_comb begin
      rem_w   = {sq_rem_q[k], sq_n_q[k][NW-1:NW-2]};
      trial_w = (SW+4)'({sq_root_q[k], 2'b01});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n_q[k+1] <= sq_n_q[k] << 2;
        if (rem_w >= trial_w) begin
          sq_rem_q[k+1]  <= (SW+2)'(rem_w - trial_w);
          sq_root_q[k+1] <= {sq_root_q[k][SW-2:0], 1'b1};
        end else begin
          sq_rem_q[k+1]  <= (SW+2)'(rem_w);
          sq_root_q[k+1] <= {sq_root_q[k][SW-2:0], 1'b0};
        end
        sq_br_q[k+1]   <= sq_br_q[k];
        sq_bad_q[k+1]  <= sq_bad_q[k];
        sq_d_q[k+1][0] <= sq_d_q[k][0];
        sq_d_q[k+1][1] <= sq_d_q[k][1];
        sq_d_q[k+1][2] <= sq_d_q[k][2];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divider setup: numerator (|d| << F) + s over denominator 2s, rounding
  // half away from zero. Quotients of 2^QW or more only saturate, so they
  // are caught by one compare here.
  // ---------------------------------------------------------------------------
  logic [SW-1:0]  s_w;
  logic [PW-1:0]  den_w;
  logic [PW-1:0]  num_w [3];
  logic [DW-1:0]  mag_w [3];

  assign s_w   = sq_root_q[SW];
  assign den_w = PW'(s_w) << 1;

  for (genvar c = 0; c < 3; c++) begin : g_num
    assign mag_w[c] = sq_d_q[SW][c][DW-1] ? DW'(-sq_d_q[SW][c]) : DW'(sq_d_q[SW][c]);
    assign num_w[c] = (PW'(mag_w[c]) << F) + PW'(s_w);
  end

  logic          dv_vld_q  [QW+1];
  logic [PW-1:0] dv_den_q  [QW+1];
  logic [PW-1:0] dv_rem_q  [QW+1][3];
  logic [QW-1:0] dv_quo_q  [QW+1][3];
  logic          dv_neg_q  [QW+1][3];
  logic          dv_ovf_q  [QW+1][3];
  logic [SW-1:0] dv_half_q [QW+1];
  logic [1:0]    dv_br_q   [QW+1];
  logic          dv_bad_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= sq_vld_q[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_den_q[0]  <= den_w;
      dv_half_q[0] <= SW'((PW'(s_w) + PW'(1)) >> 1);
      dv_br_q[0]   <= sq_br_q[SW];
      dv_bad_q[0]  <= sq_bad_q[SW];
      for (int c = 0; c < 3; c++) begin
        dv_rem_q[0][c] <= num_w[c];
        dv_quo_q[0][c] <= '0;
        dv_neg_q[0][c] <= sq_d_q[SW][c][DW-1];
        dv_ovf_q[0][c] <= num_w[c] >= (den_w << QW);
      end
    end
  end

  // One quotient bit per stage for all three components.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [PW-1:0] sub_w;
    assign sub_w = dv_den_q[j] << (QW - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_den_q[j+1]  <= dv_den_q[j];
        dv_half_q[j+1] <= dv_half_q[j];
        dv_br_q[j+1]   <= dv_br_q[j];
        dv_bad_q[j+1]  <= dv_bad_q[j];
        for (int c = 0; c < 3; c++) begin
          if (dv_rem_q[j][c] >= sub_w) begin
            dv_rem_q[j+1][c] <= dv_rem_q[j][c] - sub_w;
            dv_quo_q[j+1][c] <= {dv_quo_q[j][c][QW-2:0], 1'b1};
          end else begin
            dv_rem_q[j+1][c] <= dv_rem_q[j][c];
            dv_quo_q[j+1][c] <= {dv_quo_q[j][c][QW-2:0], 1'b0};
          end
          dv_neg_q[j+1][c] <= dv_neg_q[j][c];
          dv_ovf_q[j+1][c] <= dv_ovf_q[j][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: saturate, then place the diagonal component by branch.
  // ---------------------------------------------------------------------------
  logic [EW-1:0] ca_c, cb_c, cc_c, half_c;
  logic [EW-1:0] w_c, x_c, y_c, z_c;

  always_comb begin
    ca_c = rmq_pkg::sat_signed(dv_quo_q[QW][0], dv_neg_q[QW][0], dv_ovf_q[QW][0]);
    cb_c = rmq_pkg::sat_signed(dv_quo_q[QW][1], dv_neg_q[QW][1], dv_ovf_q[QW][1]);
    cc_c = rmq_pkg::sat_signed(dv_quo_q[QW][2], dv_neg_q[QW][2], dv_ovf_q[QW][2]);
    if (PW'(dv_half_q[QW]) > PW'(32767)) half_c = 16'h7fff;
    else half_c = EW'(dv_half_q[QW]);
    unique case (rmq_pkg::branch_e'(dv_br_q[QW]))
      rmq_pkg::BR_TRACE: begin w_c = half_c; x_c = ca_c; y_c = cb_c; z_c = cc_c; end
      rmq_pkg::BR_DIAG0: begin w_c = ca_c; x_c = half_c; y_c = cb_c; z_c = cc_c; end
      rmq_pkg::BR_DIAG1: begin w_c = ca_c; x_c = cb_c; y_c = half_c; z_c = cc_c; end
      default:           begin w_c = ca_c; x_c = cb_c; y_c = cc_c; z_c = half_c; end
    endcase
  end

  logic          out_vld_q;
  logic [EW-1:0] out_w_q, out_x_q, out_y_q, out_z_q;
  logic [1:0]    out_br_q;
  logic          out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_w_q   <= w_c;
      out_x_q   <= x_c;
      out_y_q   <= y_c;
      out_z_q   <= z_c;
      out_br_q  <= dv_br_q[QW];
      out_bad_q <= dv_bad_q[QW];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.quat_w       = out_w_q;
  assign out_o.quat_x       = out_x_q;
  assign out_o.quat_y       = out_y_q;
  assign out_o.quat_z       = out_z_q;
  assign out_o.branch_taken = out_br_q;
  assign out_o.radicand_bad = out_bad_q;

endmodule

[tb/tb.sv]
module tb;

  // The pipeline is 3 + SW + QuotW stages deep, where SW is the number of
  // square-root digits. The radicand, shifted up by the fraction bits, is
  // carried in 48 bits, so SW is 24 here. The drain wait below uses a
  // generous figure.
  localparam int unsigned FracBits   = rmq_pkg::FracBitsDef;
  localparam int unsigned PipeDepth  = 3 + 24 + rmq_pkg::QuotW;
  localparam int unsigned DrainWait  = 4 * PipeDepth;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned NumRandom  = 650;
  localparam int unsigned HoldCycles = 3 * PipeDepth;

  typedef logic signed [rmq_pkg::ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    elem_t            w, x, y, z;
    rmq_pkg::branch_e br;
    logic             bad;
  } quat_t;

  // One row of the directed table. When has_exp is set, the result is typed
  // in by hand and must also agree with the predictor.
  typedef struct packed {
    matrix_t m;
    logic    has_exp;
    quat_t   q;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmq_in_if  in_if ();
  rmq_out_if out_if ();

  rotation_matrix_to_quaternion_core #(.FRAC_BITS(FracBits)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  quat_t       quat_expected_q[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done = 1'b0;
  bit          hold_out = 1'b0;
  bit          no_idle = 1'b0;

  // Integer square root, floor, by the digit-by-digit method.
  function automatic longint unsigned isqrt_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Off-diagonal component: |d| / (2s) rounded half away from zero, signed.
  function automatic longint off_diag(input longint d, input longint unsigned s);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = ((mag << FracBits) + s) / (s << 1);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic elem_t clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return elem_t'(v);
  endfunction

  function automatic quat_t predict_quat(input matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint one_v, trace_v, rad, half, qw, qx, qy, qz;
    longint unsigned s;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one_v   = longint'(1) << FracBits;
    trace_v = a00 + a11 + a22;
    // Ties on the diagonal fall through to the later element.
    if (trace_v > 0) begin
      q.br = rmq_pkg::BR_TRACE;
      rad  = one_v + trace_v;
    end else if (a00 > a11 && a00 > a22) begin
      q.br = rmq_pkg::BR_DIAG0;
      rad  = one_v + a00 - a11 - a22;
    end else if (a11 > a22) begin
      q.br = rmq_pkg::BR_DIAG1;
      rad  = one_v + a11 - a00 - a22;
    end else begin
      q.br = rmq_pkg::BR_DIAG2;
      rad  = one_v + a22 - a00 - a11;
    end
    // A radicand that is not positive is clamped to one LSB and flagged.
    q.bad = (rad <= 0);
    if (rad <= 0) rad = 1;
    s    = isqrt_floor(longint'(rad) << FracBits);
    half = longint'((s + 1) >> 1);
    case (q.br)
      rmq_pkg::BR_TRACE: begin
        qw = half;
        qx = off_diag(a21 - a12, s);
        qy = off_diag(a02 - a20, s);
        qz = off_diag(a10 - a01, s);
      end
      rmq_pkg::BR_DIAG0: begin
        qx = half;
        qy = off_diag(a01 + a10, s);
        qz = off_diag(a20 + a02, s);
        qw = off_diag(a21 - a12, s);
      end
      rmq_pkg::BR_DIAG1: begin
        qx = off_diag(a01 + a10, s);
        qy = half;
        qz = off_diag(a12 + a21, s);
        qw = off_diag(a02 - a20, s);
      end
      default: begin
        qx = off_diag(a02 + a20, s);
        qy = off_diag(a12 + a21, s);
        qz = half;
        qw = off_diag(a10 - a01, s);
      end
    endcase
    q.w = clip16(qw);
    q.x = clip16(qx);
    q.y = clip16(qy);
    q.z = clip16(qz);
    return q;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return elem_t'($urandom_range(0, 65535));
      1:       return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
      default: return elem_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // A random matrix; for three of the four picks one diagonal element is made
  // positive and the other two negative, so that every branch is taken.
  function automatic matrix_t rand_matrix();
    matrix_t m;
    int unsigned pick;
    m    = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
            rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    pick = $urandom_range(0, 3);
    if (pick == 1) begin
      m.m00 = elem_t'($urandom_range(8000, 16384));
      m.m11 = -elem_t'($urandom_range(4000, 16384));
      m.m22 = -elem_t'($urandom_range(4000, 16384));
    end else if (pick == 2) begin
      m.m11 = elem_t'($urandom_range(8000, 16384));
      m.m00 = -elem_t'($urandom_range(4000, 16384));
      m.m22 = -elem_t'($urandom_range(4000, 16384));
    end else if (pick == 3) begin
      m.m22 = elem_t'($urandom_range(8000, 16384));
      m.m00 = -elem_t'($urandom_range(4000, 16384));
      m.m11 = -elem_t'($urandom_range(4000, 16384));
    end
    return m;
  endfunction

  // Drives one transaction and waits for it to be taken. The expectation
  // is queued at the accepting edge.
  task automatic send_matrix(input matrix_t m, input logic has_exp, input quat_t q_hand);
    quat_t q;
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.row0_col0 <= m.m00; in_if.row0_col1 <= m.m01; in_if.row0_col2 <= m.m02;
    in_if.row1_col0 <= m.m10; in_if.row1_col1 <= m.m11; in_if.row1_col2 <= m.m12;
    in_if.row2_col0 <= m.m20; in_if.row2_col1 <= m.m21; in_if.row2_col2 <= m.m22;
    do @(posedge clk_i); while (!in_if.ready);
    q = predict_quat(m);
    if (has_exp && q != q_hand) begin
      $display("Predictor disagrees with a hand-typed directed row");
      mismatch_count++;
    end
    quat_expected_q.push_back(q);
  endtask

  function automatic matrix_t mk(input int a, b, c, d, e, f, g, h, i);
    return {elem_t'(a), elem_t'(b), elem_t'(c), elem_t'(d), elem_t'(e),
            elem_t'(f), elem_t'(g), elem_t'(h), elem_t'(i)};
  endfunction

  function automatic quat_t mq(input int w, x, y, z, input rmq_pkg::branch_e br,
                               input logic bad);
    return {elem_t'(w), elem_t'(x), elem_t'(y), elem_t'(z), br, bad};
  endfunction

  // Sender process: the directed table, then the random stream.
  initial begin
    dir_row_t dir_rows[$];
    quat_t    none_q;
    none_q = '0;
    in_if.valid <= 1'b0;
    {in_if.row0_col0, in_if.row0_col1, in_if.row0_col2, in_if.row1_col0, in_if.row1_col1,
     in_if.row1_col2, in_if.row2_col0, in_if.row2_col1, in_if.row2_col2} <= '0;

    // Identity: trace branch, w = 1.0.
    dir_rows.push_back({mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
                        mq(16384, 0, 0, 0, rmq_pkg::BR_TRACE, 1'b0)});
    // 180 degrees about x, y and z: one branch each.
    dir_rows.push_back({mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
                        mq(0, 16384, 0, 0, rmq_pkg::BR_DIAG0, 1'b0)});
    dir_rows.push_back({mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b1,
                        mq(0, 0, 16384, 0, rmq_pkg::BR_DIAG1, 1'b0)});
    dir_rows.push_back({mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
                        mq(0, 0, 0, 16384, rmq_pkg::BR_DIAG2, 1'b0)});
    // All zero: trace is zero, ties fall to the third diagonal.
    dir_rows.push_back({mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_q});
    // Ties between the first and second diagonal, and first and third.
    dir_rows.push_back({mk(100, 5, 6, 7, 100, 8, 9, 10, -300), 1'b0, none_q});
    dir_rows.push_back({mk(100, 5, 6, 7, -300, 8, 9, 10, 100), 1'b0, none_q});
    // All diagonals negative: the radicand stays positive and is not flagged.
    dir_rows.push_back({mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, none_q});
    dir_rows.push_back({mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, none_q});
    dir_rows.push_back({mk(-16384, 32767, -32768, -32768, -16384, 32767, 32767, -32768,
                           -16384), 1'b0, none_q});
    // Field extremes, one row saturating components at the positive limit.
    dir_rows.push_back({mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                        1'b0, none_q});
    dir_rows.push_back({mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
                           32767), 1'b0, none_q});
    dir_rows.push_back({mk(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0),
                        1'b0, none_q});
    dir_rows.push_back({mk(-32768, -1, -1, -1, -32768, -1, -1, -1, 32767), 1'b0, none_q});
    dir_rows.push_back({mk(16384, 16384, -16384, -16384, -16384, 16384, 16384, -16384,
                           -16384), 1'b0, none_q});
    // 90 degrees about z.
    dir_rows.push_back({mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 1'b0, none_q});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) send_matrix(dir_rows[k].m, dir_rows[k].has_exp, dir_rows[k].q);
    for (int n = 0; n < NumRandom; n++) begin
      // A stretch without idling on either side.
      no_idle = (n >= 200 && n < 300);
      // Hold the receiver off for a while as the sender keeps pushing.
      if (n == 400) hold_out = 1'b1;
      send_matrix(rand_matrix(), 1'b0, none_q);
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random ready with one long hold-off, counted here.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= 23);
    end
  end

  // Result checker: compares each transaction against the oldest expectation.
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (quat_expected_q.size() == 0) begin
        report_mismatch("extra result transaction", 1, 0);
      end else begin
        want = quat_expected_q.pop_front();
        if (out_if.quat_w !== want.w) report_mismatch("quat_w", out_if.quat_w, want.w);
        if (out_if.quat_x !== want.x) report_mismatch("quat_x", out_if.quat_x, want.x);
        if (out_if.quat_y !== want.y) report_mismatch("quat_y", out_if.quat_y, want.y);
        if (out_if.quat_z !== want.z) report_mismatch("quat_z", out_if.quat_z, want.z);
        if (out_if.branch_taken !== want.br)
          report_mismatch("branch_taken", out_if.branch_taken, want.br);
        if (out_if.radicand_bad !== want.bad)
          report_mismatch("radicand_bad", out_if.radicand_bad, want.bad);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction,
  // and ends the run once the count reaches the limit.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (quat_expected_q.size() != 0 && idle_cycles < IdleLimit) @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
    end else begin
      repeat (DrainWait) @(posedge clk_i);
      if (mismatch_count == 0 && quat_expected_q.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
